// File: design/sbst_pkg.sv
// ----------------------------------------------------------------------------
// sbst_pkg
// Shared types and constants of the sorted balanced tree layout block.
// ----------------------------------------------------------------------------
package sbst_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 3;
    localparam int LENGTH_W = 4;

    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 4'd8;

    // one hop of the insertion chain
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
    } link_t;

endpackage

// File: design/sbst_if.sv
// ----------------------------------------------------------------------------
// sbst channel interfaces
// Valid/ready channels for values in, tree results out and length writes.
// ----------------------------------------------------------------------------
interface sbst_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sbst_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sbst_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sbst_pkg::VALUE_W-1:0] value_res;
    logic [sbst_pkg::POS_W-1:0]          position;
    logic                               last;

    modport source (output valid, output value_res, output position, output last, input ready);
    modport sink   (input valid, input value_res, input position, input last, output ready);
endinterface

interface sbst_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sbst_pkg::LENGTH_W-1:0]     length;

    modport source (output valid, output length, input ready);
    modport sink   (input valid, input length, output ready);
endinterface

// File: design/sbst_cell.sv
// ----------------------------------------------------------------------------
// sbst_cell
// One cell of the insertion sort chain: keeps the smaller value, passes on
// the larger one to its right neighbor.
// ----------------------------------------------------------------------------
module sbst_cell
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clear,
    input  sbst_pkg::link_t                     link_in,
    output sbst_pkg::link_t                     link_out,
    output logic signed [sbst_pkg::VALUE_W-1:0] value
);

    logic                                held_reg;
    logic                                held_next;
    logic signed [sbst_pkg::VALUE_W-1:0] value_reg;
    logic signed [sbst_pkg::VALUE_W-1:0] value_next;
    logic                                pass_valid_reg;
    logic                                pass_valid_next;
    logic signed [sbst_pkg::VALUE_W-1:0] pass_value_reg;
    logic signed [sbst_pkg::VALUE_W-1:0] pass_value_next;

    always_comb
    begin
        held_next       = held_reg;
        value_next      = value_reg;
        pass_valid_next = 1'b0;
        pass_value_next = pass_value_reg;
        if (clear)
        begin
            held_next = 1'b0;
        end
        else if (link_in.valid)
        begin
            if (!held_reg)
            begin
                held_next  = 1'b1;
                value_next = link_in.value;
            end
            else if (link_in.value < value_reg)
            begin
                value_next      = link_in.value;
                pass_valid_next = 1'b1;
                pass_value_next = value_reg;
            end
            else
            begin
                pass_valid_next = 1'b1;
                pass_value_next = link_in.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg       <= held_next;
            pass_valid_reg <= pass_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        pass_value_reg <= pass_value_next;
    end

    assign link_out = '{valid: pass_valid_reg, value: pass_value_reg};
    assign value    = value_reg;

endmodule

// File: design/sbst_walk.sv
// ----------------------------------------------------------------------------
// sbst_walk
// Preorder walker over a sorted index range: one floor midpoint per step,
// pending right halves kept on a small stack.
// ----------------------------------------------------------------------------
module sbst_walk #(
    parameter int CAPACITY = 8
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] last_idx,
    input  logic                                     advance,
    output logic                                     active,
    output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] mid
);

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SD  = $clog2(CAPACITY + 1) + 1;
    localparam int SIW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    logic           act_reg;
    logic           act_next;
    logic [IW-1:0]  lo_reg;
    logic [IW-1:0]  lo_next;
    logic [IW-1:0]  hi_reg;
    logic [IW-1:0]  hi_next;
    logic [SPW-1:0] sp_reg;
    logic [SPW-1:0] sp_next;
    logic [IW-1:0]  stack_lo [SD];
    logic [IW-1:0]  stack_hi [SD];
    logic [IW:0]    sum;
    logic [SPW-1:0] sp_dec;
    logic           push;
    logic           has_left;
    logic           has_right;

    assign sum       = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = sum[IW:1];
    assign has_left  = mid > lo_reg;
    assign has_right = mid < hi_reg;
    assign sp_dec    = sp_reg - 1'b1;

    always_comb
    begin
        act_next = act_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        sp_next  = sp_reg;
        push     = 1'b0;
        if (start)
        begin
            act_next = 1'b1;
            lo_next  = '0;
            hi_next  = last_idx;
            sp_next  = '0;
        end
        else if (advance && act_reg)
        begin
            if (has_left)
            begin
                hi_next = mid - 1'b1;
                if (has_right)
                begin
                    // park the right half until the left subtree is done
                    push    = 1'b1;
                    sp_next = sp_reg + 1'b1;
                end
            end
            else if (has_right)
            begin
                lo_next = mid + 1'b1;
            end
            else if (sp_reg != '0)
            begin
                lo_next = stack_lo[sp_dec[SIW-1:0]];
                hi_next = stack_hi[sp_dec[SIW-1:0]];
                sp_next = sp_dec;
            end
            else
            begin
                act_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            sp_reg  <= '0;
        end
        else
        begin
            act_reg <= act_next;
            sp_reg  <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (push)
        begin
            stack_lo[sp_reg[SIW-1:0]] <= mid + 1'b1;
            stack_hi[sp_reg[SIW-1:0]] <= hi_reg;
        end
    end

    assign active = act_reg;

endmodule

// File: design/sorted_balanced_bst_layout.sv
// ----------------------------------------------------------------------------
// sorted_balanced_bst_layout
// Loads a set of signed values, sorts them and sends them out in the array
// layout of a balanced binary search tree.
// ----------------------------------------------------------------------------
// Channels: din takes one value per request; dout gives value_res, position
// and last per request; cfg writes the set length (1..CAPACITY, 0 acts as 1,
// larger values saturate). The user must write the length only while the
// block is idle; the block itself does not enforce this. The request that
// completes a set of N values starts the sort: the first N stored values
// stream one per cycle into a row of insertion cells, and the sort ends once
// the row has drained. Then a preorder walker sends one result per cycle
// while dout does not stall, N in all, the final one flagged by last. din is
// ready only while a set is loading; the output register lets the next set
// start loading while the final result still waits. A dout stall holds the
// walker in place. Reset empties the set and sets the length to 8.
// ----------------------------------------------------------------------------
module sorted_balanced_bst_layout #(
    parameter int CAPACITY = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    sbst_in_if.sink     din,
    sbst_out_if.source  dout,
    sbst_cfg_if.sink    cfg
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic [sbst_pkg::LENGTH_W-1:0]       len_reg;
    logic [NW-1:0]                       lc_reg;
    logic [NW-1:0]                       lc_next;
    logic [NW-1:0]                       n_reg;
    logic [NW-1:0]                       n_eff;
    logic [NW-1:0]                       feed_idx_reg;
    logic [NW-1:0]                       ecnt_reg;
    logic                                feed_valid_reg;
    logic signed [sbst_pkg::VALUE_W-1:0] feed_value_reg;
    logic signed [sbst_pkg::VALUE_W-1:0] store [CAPACITY];
    sbst_pkg::link_t                     links [CAPACITY+1];
    logic [CAPACITY:0]                   link_valid;
    logic signed [sbst_pkg::VALUE_W-1:0] cell_val [CAPACITY];
    logic                                accept;
    logic                                fire;
    logic                                sort_done;
    logic                                walk_active;
    logic [IW-1:0]                       walk_mid;
    logic                                adv;
    logic                                out_valid_reg;
    logic signed [sbst_pkg::VALUE_W-1:0] out_value_reg;
    logic [sbst_pkg::POS_W-1:0]          out_pos_reg;
    logic                                out_last_reg;

    // effective set length
    always_comb
    begin
        if (len_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(len_reg) > 32'(CAPACITY))
        begin
            n_eff = NW'(CAPACITY);
        end
        else
        begin
            n_eff = NW'(len_reg);
        end
    end

    assign din.ready = (state_reg == ST_LOAD);
    assign cfg.ready = 1'b1;
    assign accept    = din.valid && din.ready;
    assign lc_next   = (lc_reg == NW'(CAPACITY)) ? lc_reg : lc_reg + 1'b1;
    assign fire      = accept && (lc_next >= n_eff);

    assign links[0] = '{valid: feed_valid_reg, value: feed_value_reg};
    always_comb
    begin
        for (int i = 0; i <= CAPACITY; i++)
        begin
            link_valid[i] = links[i].valid;
        end
    end

    assign sort_done = (state_reg == ST_SORT) && (feed_idx_reg == n_reg) && !(|link_valid);
    assign adv       = (state_reg == ST_EMIT) && walk_active && (!out_valid_reg || dout.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (fire)
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                if (sort_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!walk_active)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            len_reg        <= sbst_pkg::LENGTH_RESET;
            lc_reg         <= '0;
            n_reg          <= NW'(1);
            feed_idx_reg   <= '0;
            feed_valid_reg <= 1'b0;
            ecnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                len_reg <= cfg.length;
            end
            if (fire)
            begin
                lc_reg       <= '0;
                n_reg        <= n_eff;
                feed_idx_reg <= '0;
            end
            else if (accept)
            begin
                lc_reg <= lc_next;
            end
            if ((state_reg == ST_SORT) && (feed_idx_reg < n_reg))
            begin
                feed_valid_reg <= 1'b1;
                feed_idx_reg   <= feed_idx_reg + 1'b1;
            end
            else
            begin
                feed_valid_reg <= 1'b0;
            end
            if (sort_done)
            begin
                ecnt_reg <= '0;
            end
            else if (adv)
            begin
                ecnt_reg <= ecnt_reg + 1'b1;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (lc_reg < NW'(CAPACITY)))
        begin
            store[lc_reg[IW-1:0]] <= din.value;
        end
        if (feed_idx_reg < n_reg)
        begin
            feed_value_reg <= store[feed_idx_reg[IW-1:0]];
        end
        if (adv)
        begin
            out_value_reg <= cell_val[walk_mid];
            out_pos_reg   <= ecnt_reg[sbst_pkg::POS_W-1:0];
            out_last_reg  <= (ecnt_reg == (n_reg - 1'b1));
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        sbst_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (fire),
            .link_in  (links[g]),
            .link_out (links[g+1]),
            .value    (cell_val[g])
        );
    end

    sbst_walk #(
        .CAPACITY (CAPACITY)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sort_done),
        .last_idx (IW'(n_reg - 1'b1)),
        .advance  (adv),
        .active   (walk_active),
        .mid      (walk_mid)
    );

    assign dout.valid     = out_valid_reg;
    assign dout.value_res = out_value_reg;
    assign dout.position  = out_pos_reg;
    assign dout.last      = out_last_reg;

endmodule

// File: tb/tb_sorted_balanced_bst_layout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_balanced_bst_layout
// Loads value sets of every length, predicts the sorted balanced tree layout
// of each full set and checks every result field against that prediction,
// under random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb_sorted_balanced_bst_layout;

    localparam int VALUE_W  = sbst_pkg::VALUE_W;
    localparam int POS_W    = sbst_pkg::POS_W;
    localparam int LENGTH_W = sbst_pkg::LENGTH_W;

    localparam int CAPACITY       = 8;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 36;
    localparam int HOLD_CYCLES    = 300;

    typedef logic signed [VALUE_W-1:0] value_t;

    localparam value_t VALUE_MIN = 32'sh8000_0000;
    localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        value_t             value_res;
        logic [POS_W-1:0]   position;
        logic               last;
    } tree_slot_t;

    logic clk;
    logic rst_n;

    sbst_in_if  din_if ();
    sbst_out_if res_if ();
    sbst_cfg_if len_if ();

    sorted_balanced_bst_layout #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (res_if),
        .cfg   (len_if)
    );

    // predictor state
    value_t             held_values [CAPACITY];
    int unsigned        loaded_count;
    logic [LENGTH_W-1:0] set_length;
    value_t             ordered_set [CAPACITY];
    int unsigned        slot_count;
    int unsigned        run_length;
    tree_slot_t         tree_slots_due [$];

    int unsigned mismatch_count;
    bit          calm_stretch;
    int unsigned hold_request;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned effective_length(input logic [LENGTH_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > CAPACITY)
            return CAPACITY;
        return int'(len);
    endfunction

    // preorder walk with floor midpoint
    function automatic void lay_out_subtree(input int lo, input int hi);
        int         mid;
        tree_slot_t slot;
        if (lo > hi)
            return;
        mid             = (lo + hi) / 2;
        slot.value_res  = ordered_set[mid];
        slot.position   = slot_count[POS_W-1:0];
        slot.last       = (slot_count + 1 == run_length);
        tree_slots_due.push_back(slot);
        slot_count++;
        lay_out_subtree(lo, mid - 1);
        lay_out_subtree(mid + 1, hi);
    endfunction

    function automatic void take_value(input value_t v);
        int unsigned n;
        int          j;
        value_t      key;
        n = effective_length(set_length);
        if (loaded_count < CAPACITY)
        begin
            held_values[loaded_count] = v;
            loaded_count++;
        end
        if (loaded_count < n)
            return;
        // a lowered length uses only the first n held values
        for (int i = 0; i < n; i++)
            ordered_set[i] = held_values[i];
        for (int i = 1; i < n; i++)
        begin
            key = ordered_set[i];
            j   = i;
            while (j > 0 && key < ordered_set[j-1])
            begin
                ordered_set[j] = ordered_set[j-1];
                j--;
            end
            ordered_set[j] = key;
        end
        run_length = n;
        slot_count = 0;
        lay_out_subtree(0, int'(n) - 1);
        loaded_count = 0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_result();
        tree_slot_t due;
        if (tree_slots_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result value %0d position %0d",
                                      res_if.value_res, res_if.position));
            return;
        end
        due = tree_slots_due.pop_front();
        if (res_if.value_res !== due.value_res)
            report_mismatch($sformatf("value_res got %0d want %0d at position %0d",
                                      res_if.value_res, due.value_res, due.position));
        if (res_if.position !== due.position)
            report_mismatch($sformatf("position got %0d want %0d",
                                      res_if.position, due.position));
        if (res_if.last !== due.last)
            report_mismatch($sformatf("last got %0b want %0b at position %0d",
                                      res_if.last, due.last, due.position));
    endtask

    // sampled between edges, so the handshake seen holds at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            check_result();
    end

    // result side ready, with random stalls and a counted hold-off
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else if (calm_stretch)
                res_if.ready <= 1'b1;
            else
                res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((din_if.valid === 1'b1 && din_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
                (len_if.valid === 1'b1 && len_if.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t ns watchdog: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("sorted_balanced_bst_layout regression: fail");
        $finish;
    end

    task automatic send_value(input value_t v);
        bit took;
        while (!calm_stretch && $urandom_range(99) < IDLE_PCT)
        begin
            din_if.valid <= 1'b0;
            @(posedge clk);
        end
        din_if.valid <= 1'b1;
        din_if.value <= v;
        do
        begin
            @(negedge clk);
            took = (din_if.ready === 1'b1);
            @(posedge clk);
        end
        while (!took);
        take_value(v);
    endtask

    // all results drained plus a margin for a sort still under way
    task automatic wait_idle();
        din_if.valid <= 1'b0;
        while (tree_slots_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [LENGTH_W-1:0] len);
        bit took;
        wait_idle();
        len_if.valid  <= 1'b1;
        len_if.length <= len;
        do
        begin
            @(negedge clk);
            took = (len_if.ready === 1'b1);
            @(posedge clk);
        end
        while (!took);
        set_length = len;
        len_if.valid <= 1'b0;
    endtask

    function automatic value_t pick_value();
        case ($urandom_range(3))
            0: return value_t'(int'($urandom_range(6)) - 3);
            1:
            begin
                case ($urandom_range(3))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return value_t'($urandom);
        endcase
    endfunction

    // reset length of 8, extreme values and a duplicate
    task automatic test_extremes_at_reset_length();
        send_value(VALUE_MAX);
        send_value(VALUE_MIN);
        send_value(32'sd0);
        send_value(-32'sd1);
        send_value(32'sd1);
        send_value(VALUE_MIN);
        send_value(32'sh5555_5555);
        send_value(32'shAAAA_AAAA);
    endtask

    // zero acts as one
    task automatic test_short_lengths();
        write_length(4'd0);
        send_value(32'sh1234_5678);
        write_length(4'd1);
        send_value(-32'sd7);
    endtask

    task automatic test_length_saturation();
        write_length(4'd15);
        repeat (CAPACITY) send_value(pick_value());
    endtask

    // length dropped below the count already held fires on the next value
    task automatic test_length_lowered_mid_load();
        send_value(32'sd40);
        send_value(-32'sd40);
        send_value(32'sd5);
        send_value(VALUE_MIN);
        write_length(4'd2);
        send_value(VALUE_MAX);
    endtask

    task automatic test_random_sets();
        int unsigned         sent;
        int unsigned         n;
        int unsigned         sets;
        logic [LENGTH_W-1:0] len;
        sent = 0;
        while (sent < 170)
        begin
            case ($urandom_range(9))
                0: len = 4'd0;
                1: len = LENGTH_W'($urandom_range(15, 9));
                2: len = 4'd1;
                3: len = 4'd8;
                default: len = LENGTH_W'($urandom_range(8, 1));
            endcase
            write_length(len);
            n    = effective_length(len);
            sets = $urandom_range(4, 1);
            repeat (sets * n) send_value(pick_value());
            sent += sets * n;
            // a broken set left half loaded across the next length change
            if (n > 1 && $urandom_range(5) == 0)
            begin
                repeat ($urandom_range(n - 1, 1)) send_value(pick_value());
                sent++;
            end
        end
    endtask

    task automatic test_no_idle_stretch();
        write_length(4'd8);
        calm_stretch = 1'b1;
        repeat (24) send_value(pick_value());
        write_length(4'd5);
        repeat (15) send_value(pick_value());
        wait_idle();
        calm_stretch = 1'b0;
    endtask

    // output held off long enough for the input to stall
    task automatic test_output_hold_off();
        write_length(4'd8);
        hold_request = HOLD_CYCLES;
        repeat (3 * CAPACITY) send_value(pick_value());
    endtask

    initial begin
        mismatch_count = 0;
        calm_stretch   = 1'b0;
        hold_request   = 0;
        loaded_count   = 0;
        set_length     = sbst_pkg::LENGTH_RESET;
        run_length     = 0;
        slot_count     = 0;
        rst_n         <= 1'b0;
        din_if.valid  <= 1'b0;
        din_if.value  <= '0;
        len_if.valid  <= 1'b0;
        len_if.length <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes_at_reset_length();
        test_short_lengths();
        test_length_saturation();
        test_length_lowered_mid_load();
        test_random_sets();
        test_no_idle_stretch();
        test_output_hold_off();

        wait_idle();
        if (mismatch_count == 0)
            $display("sorted_balanced_bst_layout regression: pass");
        else
            $display("sorted_balanced_bst_layout regression: fail");
        $finish;
    end

endmodule

// File: files.f
design/sbst_pkg.sv
design/sbst_if.sv
design/sbst_cell.sv
design/sbst_walk.sv
design/sorted_balanced_bst_layout.sv
tb/tb_sorted_balanced_bst_layout.sv
